### sv/window_line_fit_intercept_unit_assert.svh
// Assertion macros for the window line fit intercept unit.
`ifndef WINDOW_LINE_FIT_INTERCEPT_UNIT_ASSERT_SVH
`define WINDOW_LINE_FIT_INTERCEPT_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WLFI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wlfi: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define WLFI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wlfi: next-cycle check failed");

`endif

### sv/wlfi_pkg.sv
// Shared constants for the window line fit intercept unit.
`timescale 1ns / 1ps

package wlfi_pkg;

  localparam int CW         = 14;
  localparam int LIM_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam int WINDOW_DEF = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CROSSING_LINE_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HALF_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TARGET      = 2'd2;

  localparam logic signed [CW-1:0] CROSSING_LINE_X_RST  = -14'sd4800;
  localparam logic [LIM_W-1:0]     LIMIT_HALF_WIDTH_RST = 13'd272;
  localparam logic [LIM_W-1:0]     EDGE_TARGET_RST      = 13'd240;

  localparam int COORD_MAX     = 8191;
  localparam int COORD_MIN_MAG = 8192;

endpackage

### sv/wlfi_if.sv
// Sample and result channel interfaces.
`timescale 1ns / 1ps

interface wlfi_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [wlfi_pkg::CW-1:0] pos_x;
  logic signed [wlfi_pkg::CW-1:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink (input valid, input pos_x, input pos_y, output ready);
endinterface

interface wlfi_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [wlfi_pkg::CW-1:0] cross_y;
  logic                           fit_valid;
  logic                           was_clamped;

  modport source (output valid, output cross_y, output fit_valid, output was_clamped,
                  input ready);
  modport sink (input valid, input cross_y, input fit_valid, input was_clamped,
                output ready);
endinterface

### sv/wlfi_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module wlfi_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/window_line_fit_intercept_unit.sv
// Sliding-window least-squares line fit with crossing-line prediction.
//
//   channel | dir | payload                          | transfer
//   in_chan | in  | pos_x, pos_y                     | valid && ready
//   out_chan| out | cross_y, fit_valid, was_clamped  | valid && ready
//   cfg_*   | in  | cfg_index, cfg_data              | cfg_we
//
// Full window and sound fit: the quotient comes from a restoring divider that gives
// one quotient bit per cycle. The sequence ends early when the window is not full or
// the fit is degenerate. One item at a time; the next sample is accepted once the
// result is loaded into the output register.
// Reset: configuration to defaults, window empty; no clearing pass, the fill
// count masks unwritten RAM slots.
// A result waiting on out_chan holds the sequencer in idle with its result pending;
// a new sample is taken while the previous result waits in the output register.
`timescale 1ns / 1ps
`include "window_line_fit_intercept_unit_assert.svh"

module window_line_fit_intercept_unit #(
  parameter int WINDOW = wlfi_pkg::WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  wlfi_in_if.sink                            in_chan,
  wlfi_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [wlfi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wlfi_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW   = wlfi_pkg::CW;
  localparam int LG   = $clog2(WINDOW);
  localparam int AW   = (LG < 1) ? 1 : LG;
  localparam int FW   = $clog2(WINDOW + 1);
  localparam int SXW  = CW + LG;
  localparam int SQW  = 2 * CW + LG;
  localparam int DW   = 2 * CW + 2 * LG + 1;
  localparam int NW   = 3 * CW + 2 * LG + 1;
  localparam int PW   = DW + SXW;
  localparam int CNTW = $clog2(NW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_OLD  = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_M4   = 4'd5;
  localparam logic [3:0] S_M5   = 4'd6;
  localparam logic [3:0] S_M6   = 4'd7;
  localparam logic [3:0] S_M7   = 4'd8;
  localparam logic [3:0] S_M8   = 4'd9;
  localparam logic [3:0] S_M9   = 4'd10;
  localparam logic [3:0] S_M10  = 4'd11;
  localparam logic [3:0] S_NUM  = 4'd12;
  localparam logic [3:0] S_ABS  = 4'd13;
  localparam logic [3:0] S_DIV  = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       done_r;
  logic       done_nxt;

  logic signed [CW-1:0]          clx_r;
  logic [wlfi_pkg::LIM_W-1:0]    lim_r;
  logic [wlfi_pkg::LIM_W-1:0]    edge_r;

  logic signed [CW-1:0]  x_r;
  logic signed [CW-1:0]  y_r;
  logic signed [CW-1:0]  old_x_r;
  logic signed [CW-1:0]  old_y_r;
  logic signed [CW-1:0]  old_x_mux;
  logic signed [CW-1:0]  old_y_mux;
  logic [AW-1:0]         slot_r;
  logic [FW-1:0]         fill_r;
  logic [FW-1:0]         fill_inc;

  logic signed [SXW-1:0] sum_x_r;
  logic signed [SXW-1:0] sum_y_r;
  logic signed [SQW-1:0] sum_yy_r;
  logic signed [SQW-1:0] sum_xy_r;
  logic signed [DW-1:0]  den_r;
  logic signed [DW-1:0]  kn_r;
  logic signed [NW-1:0]  bn_r;
  logic signed [NW-1:0]  num_r;

  logic signed [DW-1:0]  mul_a;
  logic signed [SXW-1:0] mul_b;
  logic signed [PW-1:0]  prod_r;

  logic [NW-1:0]   dvd_r;
  logic [DW-1:0]   dvs_r;
  logic [DW-1:0]   rem_r;
  logic            neg_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_diff;

  logic signed [CW:0] q_sat;
  logic signed [CW:0] lim_s;
  logic signed [CW:0] edge_s;
  logic               clamp;

  logic signed [CW-1:0] res_cross_r;
  logic                 res_valid_r;
  logic                 res_clamp_r;

  logic                 out_valid_r;
  logic signed [CW-1:0] out_cross_r;
  logic                 out_fit_r;
  logic                 out_clamp_r;

  logic            in_xfer;
  logic [2*CW-1:0] ram_rdata;

  assign in_chan.ready = (state_r == S_IDLE) && !done_r;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.cross_y     = out_cross_r;
  assign out_chan.fit_valid   = out_fit_r;
  assign out_chan.was_clamped = out_clamp_r;

  wlfi_ram #(
    .WIDTH (2 * CW),
    .DEPTH (WINDOW)
  ) u_window_ram (
    .clk   (clk),
    .we    (state_r == S_OLD),
    .waddr (slot_r[LG-1:0]),
    .wdata ({x_r, y_r}),
    .re    (in_xfer),
    .raddr (slot_r[LG-1:0]),
    .rdata (ram_rdata)
  );

  assign old_x_mux = (fill_r == FW'(WINDOW)) ? signed'(ram_rdata[2*CW-1:CW]) : '0;
  assign old_y_mux = (fill_r == FW'(WINDOW)) ? signed'(ram_rdata[CW-1:0]) : '0;
  assign fill_inc  = (fill_r == FW'(WINDOW)) ? fill_r : fill_r + FW'(1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_OLD: begin
        mul_a = DW'(y_r);
        mul_b = SXW'(y_r);
      end
      S_M1: begin
        mul_a = DW'(old_y_r);
        mul_b = SXW'(old_y_r);
      end
      S_M2: begin
        mul_a = DW'(x_r);
        mul_b = SXW'(y_r);
      end
      S_M3: begin
        mul_a = DW'(old_x_r);
        mul_b = SXW'(old_y_r);
      end
      S_M4: begin
        mul_a = DW'(sum_yy_r);
        mul_b = SXW'(WINDOW);
      end
      S_M5: begin
        mul_a = DW'(sum_y_r);
        mul_b = sum_y_r;
      end
      S_M6: begin
        mul_a = DW'(sum_xy_r);
        mul_b = SXW'(WINDOW);
      end
      S_M7: begin
        mul_a = DW'(sum_y_r);
        mul_b = sum_x_r;
      end
      S_M8: begin
        mul_a = DW'(sum_yy_r);
        mul_b = sum_x_r;
      end
      S_M9: begin
        mul_a = DW'(sum_xy_r);
        mul_b = sum_y_r;
      end
      S_M10: begin
        mul_a = den_r;
        mul_b = SXW'(clx_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rem_sh   = {rem_r, dvd_r[NW-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};

  always_comb begin
    if (neg_r) begin
      if (dvd_r > NW'(wlfi_pkg::COORD_MIN_MAG)) begin
        q_sat = -(CW + 1)'(wlfi_pkg::COORD_MIN_MAG);
      end else begin
        q_sat = -signed'({1'b0, dvd_r[CW-1:0]});
      end
    end else begin
      if (dvd_r > NW'(wlfi_pkg::COORD_MAX)) begin
        q_sat = (CW + 1)'(wlfi_pkg::COORD_MAX);
      end else begin
        q_sat = signed'({1'b0, dvd_r[CW-1:0]});
      end
    end
  end

  assign lim_s  = signed'({2'b00, lim_r});
  assign edge_s = signed'({2'b00, edge_r});
  assign clamp  = (q_sat > lim_s) || (q_sat < -lim_s);

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    case (state_r)
      S_IDLE: begin
        if (done_r) begin
          if (!out_valid_r || out_chan.ready) begin
            done_nxt = 1'b0;
          end
        end else if (in_xfer) begin
          state_nxt = S_OLD;
        end
      end
      S_OLD:  state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_M4;
      S_M4: begin
        if (fill_inc == FW'(WINDOW)) begin
          state_nxt = S_M5;
        end else begin
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
        end
      end
      S_M5:   state_nxt = S_M6;
      S_M6:   state_nxt = S_M7;
      S_M7:   state_nxt = S_M8;
      S_M8:   state_nxt = S_M9;
      S_M9:   state_nxt = S_M10;
      S_M10: begin
        if (den_r == '0 || kn_r == '0) begin
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
        end else begin
          state_nxt = S_NUM;
        end
      end
      S_NUM:  state_nxt = S_ABS;
      S_ABS:  state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
        done_nxt  = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      done_r      <= 1'b0;
      slot_r      <= '0;
      fill_r      <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_yy_r    <= '0;
      sum_xy_r    <= '0;
      out_valid_r <= 1'b0;
      clx_r       <= wlfi_pkg::CROSSING_LINE_X_RST;
      lim_r       <= wlfi_pkg::LIMIT_HALF_WIDTH_RST;
      edge_r      <= wlfi_pkg::EDGE_TARGET_RST;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;

      if (cfg_we) begin
        case (cfg_index)
          wlfi_pkg::CFG_CROSSING_LINE_X:  clx_r  <= signed'(cfg_data[CW-1:0]);
          wlfi_pkg::CFG_LIMIT_HALF_WIDTH: lim_r  <= cfg_data[wlfi_pkg::LIM_W-1:0];
          wlfi_pkg::CFG_EDGE_TARGET:      edge_r <= cfg_data[wlfi_pkg::LIM_W-1:0];
          default: ;
        endcase
      end

      if (done_r && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_OLD: begin
          sum_x_r <= sum_x_r + SXW'(x_r) - SXW'(old_x_mux);
          sum_y_r <= sum_y_r + SXW'(y_r) - SXW'(old_y_mux);
        end
        S_M1: sum_yy_r <= sum_yy_r + signed'(prod_r[SQW-1:0]);
        S_M2: sum_yy_r <= sum_yy_r - signed'(prod_r[SQW-1:0]);
        S_M3: sum_xy_r <= sum_xy_r + signed'(prod_r[SQW-1:0]);
        S_M4: begin
          sum_xy_r <= sum_xy_r - signed'(prod_r[SQW-1:0]);
          fill_r   <= fill_inc;
          if (slot_r == AW'(WINDOW - 1)) begin
            slot_r <= '0;
          end else begin
            slot_r <= slot_r + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;

    if (in_xfer) begin
      x_r <= in_chan.pos_x;
      y_r <= in_chan.pos_y;
    end

    if (done_r && (!out_valid_r || out_chan.ready)) begin
      out_cross_r <= res_cross_r;
      out_fit_r   <= res_valid_r;
      out_clamp_r <= res_clamp_r;
    end

    case (state_r)
      S_OLD: begin
        old_x_r <= old_x_mux;
        old_y_r <= old_y_mux;
      end
      S_M4: begin
        res_cross_r <= '0;
        res_valid_r <= 1'b0;
        res_clamp_r <= 1'b0;
      end
      S_M5:  den_r <= signed'(prod_r[DW-1:0]);
      S_M6:  den_r <= den_r - signed'(prod_r[DW-1:0]);
      S_M7:  kn_r  <= signed'(prod_r[DW-1:0]);
      S_M8:  kn_r  <= kn_r - signed'(prod_r[DW-1:0]);
      S_M9:  bn_r  <= signed'(prod_r[NW-1:0]);
      S_M10: bn_r  <= bn_r - signed'(prod_r[NW-1:0]);
      S_NUM: num_r <= signed'(prod_r[NW-1:0]) - bn_r;
      S_ABS: begin
        dvd_r <= num_r[NW-1] ? NW'(-num_r) : NW'(num_r);
        dvs_r <= kn_r[DW-1] ? DW'(-kn_r) : DW'(kn_r);
        neg_r <= num_r[NW-1] ^ kn_r[DW-1];
        rem_r <= '0;
        cnt_r <= CNTW'(NW - 1);
      end
      S_DIV: begin
        cnt_r <= cnt_r - CNTW'(1);
        if (!rem_diff[DW]) begin
          rem_r <= rem_diff[DW-1:0];
          dvd_r <= {dvd_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[DW-1:0];
          dvd_r <= {dvd_r[NW-2:0], 1'b0};
        end
      end
      S_FIN: begin
        res_valid_r <= 1'b1;
        res_clamp_r <= clamp;
        if (clamp) begin
          res_cross_r <= (q_sat > 0) ? edge_s[CW-1:0] : CW'(-edge_s);
        end else begin
          res_cross_r <= q_sat[CW-1:0];
        end
      end
      default: ;
    endcase
  end

  `WLFI_ASSERT_NEXT(a_xfer_reads_window, in_xfer, state_r == S_OLD)
  `WLFI_ASSERT_SAME(a_div_needs_full, state_r == S_DIV, fill_r == FW'(WINDOW))
  `WLFI_ASSERT_SAME(a_div_nonzero_divisor, state_r == S_ABS, kn_r != '0)
  `WLFI_ASSERT_SAME(a_clamp_implies_fit, out_valid_r && out_clamp_r, out_fit_r)
  `WLFI_ASSERT_SAME(a_invalid_is_zero, out_valid_r && !out_fit_r, out_cross_r == '0)

endmodule

### tb/sv/tb_window_line_fit_intercept_unit.sv
// Testbench for the window line fit intercept unit: directed fills, random tracks, checked.
`timescale 1ns / 1ps

module tb_window_line_fit_intercept_unit;

  localparam int CW            = wlfi_pkg::CW;
  localparam int LIM_W         = wlfi_pkg::LIM_W;
  localparam int CFG_IDX_W     = wlfi_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W    = wlfi_pkg::CFG_DATA_W;
  localparam int COORD_MAX     = wlfi_pkg::COORD_MAX;
  localparam int COORD_MIN_MAG = wlfi_pkg::COORD_MIN_MAG;
  localparam int WINDOW_LEN = wlfi_pkg::WINDOW_DEF;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] cross_y;
    logic                 fit_valid;
    logic                 was_clamped;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wlfi_in_if in_chan ();
  wlfi_out_if out_chan ();

  window_line_fit_intercept_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Model state and register shadows.
  longint win_x [WINDOW_LEN];
  longint win_y [WINDOW_LEN];
  int     slot;
  int     held;
  longint sum_x, sum_y, sum_yy, sum_xy;
  longint line_x, half_width, edge_mag;

  crossing_t expected_crossings [$];
  int  mismatches;
  int  samples_sent;
  int  crossings_checked;
  int  fitted_count;
  int  clamped_count;
  int  config_phases;
  bit  quiet;
  int  stall_left;
  crossing_t seen;
  crossing_t want;

  function automatic crossing_t predict_crossing(input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y);
    longint sx, sy, ox, oy, den, kn, bn, num, q;
    crossing_t r;
    sx = x;
    sy = y;
    ox = win_x[slot];
    oy = win_y[slot];
    sum_x  += sx - ox;
    sum_y  += sy - oy;
    sum_yy += sy * sy - oy * oy;
    sum_xy += sx * sy - ox * oy;
    win_x[slot] = sx;
    win_y[slot] = sy;
    slot = (slot + 1) % WINDOW_LEN;
    if (held < WINDOW_LEN) held++;
    r = '0;
    if (held == WINDOW_LEN) begin
      den = WINDOW_LEN * sum_yy - sum_y * sum_y;
      kn  = WINDOW_LEN * sum_xy - sum_y * sum_x;
      if (den != 0 && kn != 0) begin
        bn  = sum_yy * sum_x - sum_y * sum_xy;
        num = line_x * den - bn;
        q   = num / kn;
        if (q > COORD_MAX) q = COORD_MAX;
        if (q < -COORD_MIN_MAG) q = -COORD_MIN_MAG;
        if (q > half_width || q < -half_width) begin
          q = (q > 0) ? edge_mag : -edge_mag;
          r.was_clamped = 1'b1;
        end
        r.cross_y   = q[CW-1:0];
        r.fit_valid = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] to_coord(input int v);
    if (v > COORD_MAX) return CW'(COORD_MAX);
    if (v < -COORD_MIN_MAG) return CW'(-COORD_MIN_MAG);
    return CW'(v);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic send_sample(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
    crossing_t next_crossing;
    if (!quiet && $urandom_range(99) < 6) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(90, 1)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.pos_x <= x;
    in_chan.pos_y <= y;
    do @(posedge clk); while (!in_chan.ready);
    next_crossing = predict_crossing(x, y);
    expected_crossings = {expected_crossings, next_crossing};
    samples_sent++;
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (expected_crossings.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic signed [CW-1:0] lx, input logic [LIM_W-1:0] hw,
                            input logic [LIM_W-1:0] et);
    cfg_we    <= 1'b1;
    cfg_index <= wlfi_pkg::CFG_CROSSING_LINE_X;
    cfg_data  <= lx;
    @(posedge clk);
    line_x = lx;
    cfg_index <= wlfi_pkg::CFG_LIMIT_HALF_WIDTH;
    cfg_data  <= {1'($urandom_range(1)), hw};
    @(posedge clk);
    half_width = hw;
    cfg_index <= wlfi_pkg::CFG_EDGE_TARGET;
    cfg_data  <= {1'($urandom_range(1)), et};
    @(posedge clk);
    edge_mag = et;
    cfg_index <= CFG_SPARE;
    cfg_data  <= CFG_DATA_W'($urandom());
    @(posedge clk);
    cfg_we <= 1'b0;
    config_phases++;
  endtask

  task automatic send_track();
    int kind, len, y0, dy, yc, span, kx, ky, jitter, c, yv, xv;
    kind = $urandom_range(99);
    if (kind < 70) begin
      len = $urandom_range(20, 8);
      y0  = int'($urandom_range(16383)) - 8192;
      if ($urandom_range(3) == 0) dy = int'($urandom_range(1200)) - 600;
      else dy = int'($urandom_range(64)) - 32;
      span = (half_width + 64 > COORD_MAX) ? COORD_MAX : int'(half_width) + 64;
      yc = int'($urandom_range(2 * span)) - span;
      kx = int'($urandom_range(80)) - 40;
      ky = $urandom_range(8, 1);
      jitter = $urandom_range(4);
      for (int i = 0; i < len; i++) begin
        yv = y0 + i * dy;
        xv = int'(line_x) + ((yv - yc) * kx) / ky
             + int'($urandom_range(2 * jitter)) - jitter;
        send_sample(to_coord(xv), to_coord(yv));
      end
    end else if (kind < 82) begin
      len = $urandom_range(12, 8);
      c   = int'($urandom_range(16383)) - 8192;
      for (int i = 0; i < len; i++) begin
        if (kind < 76) send_sample(CW'($urandom()), to_coord(c));
        else send_sample(to_coord(c), CW'($urandom()));
      end
    end else begin
      len = $urandom_range(10, 1);
      for (int i = 0; i < len; i++) send_sample(CW'($urandom()), CW'($urandom()));
    end
  endtask

  task automatic test_window_fill_and_degenerate();
    int xs [8] = '{-8192, 8191, 0, -1, 1, 4096, -4096, 8191};
    int ys [8] = '{-8192, 8191, 0, 1, -1, 5000, -5000, 8191};
    foreach (xs[i]) send_sample(to_coord(xs[i]), to_coord(100));
    foreach (ys[i]) send_sample(to_coord(-8192), to_coord(ys[i]));
  endtask

  task automatic test_clean_crossing();
    for (int yv = -3; yv <= 4; yv++) send_sample(to_coord(16 * (yv - 5) - 4800), to_coord(yv));
  endtask

  task automatic test_tracks(input logic signed [CW-1:0] lx, input logic [LIM_W-1:0] hw,
                             input logic [LIM_W-1:0] et, input int count, input bit no_idle);
    int start;
    wait_idle();
    set_config(lx, hw, et);
    quiet = no_idle;
    start = samples_sent;
    while (samples_sent - start < count) send_track();
  endtask

  // Check each result transfer against the oldest expected crossing.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        seen = '{out_chan.cross_y, out_chan.fit_valid, out_chan.was_clamped};
        if (expected_crossings.size() == 0) begin
          flag_mismatch("result transfer with no crossing pending");
        end else begin
          want = expected_crossings.pop_front();
          crossings_checked++;
          if (want.fit_valid) fitted_count++;
          if (want.was_clamped) clamped_count++;
          if (seen.cross_y !== want.cross_y)
            flag_mismatch($sformatf("cross_y %0d, want %0d", seen.cross_y, want.cross_y));
          if (seen.fit_valid !== want.fit_valid)
            flag_mismatch($sformatf("fit_valid %b, want %b", seen.fit_valid, want.fit_valid));
          if (seen.was_clamped !== want.was_clamped)
            flag_mismatch($sformatf("was_clamped %b, want %b",
                                    seen.was_clamped, want.was_clamped));
        end
      end
      if (stall_left > 0) stall_left--;
      else if (!quiet && $urandom_range(99) == 0) stall_left = $urandom_range(12, 1);
      out_chan.ready <= (stall_left == 0);
    end else begin
      out_chan.ready <= 1'b0;
    end
  end

  initial begin
    #15_000_000;
    $display("tb_window_line_fit_intercept_unit: FAIL");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_chan.valid  = 1'b0;
    in_chan.pos_x  = '0;
    in_chan.pos_y  = '0;
    foreach (win_x[i]) begin
      win_x[i] = 0;
      win_y[i] = 0;
    end
    line_x     = wlfi_pkg::CROSSING_LINE_X_RST;
    half_width = wlfi_pkg::LIMIT_HALF_WIDTH_RST;
    edge_mag   = wlfi_pkg::EDGE_TARGET_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_window_fill_and_degenerate();
    test_clean_crossing();
    test_tracks(wlfi_pkg::CROSSING_LINE_X_RST, wlfi_pkg::LIMIT_HALF_WIDTH_RST,
                wlfi_pkg::EDGE_TARGET_RST, 320, 1'b1);
    test_tracks(-14'sd8192, 13'd0, 13'd8191, 300, 1'b0);
    test_tracks(14'sd8191, 13'd8191, 13'd0, 300, 1'b0);
    test_tracks(14'sd0, LIM_W'($urandom()), LIM_W'($urandom()), 300, 1'b0);
    test_tracks(CW'($urandom()), LIM_W'($urandom_range(600)), LIM_W'($urandom()), 330, 1'b0);
    test_tracks(CW'($urandom()), LIM_W'($urandom()), LIM_W'($urandom_range(300)), 330, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d samples over %0d register settings; %0d results checked", samples_sent,
             config_phases, crossings_checked);
    $display("%0d fits valid, %0d clamped to the edge target, %0d mismatches", fitted_count,
             clamped_count, mismatches);
    if (mismatches == 0) $display("tb_window_line_fit_intercept_unit: PASS");
    else $display("tb_window_line_fit_intercept_unit: FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/wlfi_pkg.sv
sv/wlfi_if.sv
sv/wlfi_ram.sv
sv/window_line_fit_intercept_unit.sv
tb/sv/tb_window_line_fit_intercept_unit.sv
